// ----- rtl/adsr_envelope_gain_unit_macros.svh -----
// Assertion macros for the ADSR envelope gain unit.
`ifndef ADSR_ENVELOPE_GAIN_UNIT_MACROS_SVH
`define ADSR_ENVELOPE_GAIN_UNIT_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define AEG_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication.
`define AEG_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ----- rtl/aeg_pkg.sv -----
// Package: constants, types and shared helpers for the ADSR envelope gain unit.
`timescale 1ns / 1ps
package aeg_pkg;
    localparam int TIME_BITS_DEF   = 24;
    localparam int SAMPLE_BITS_DEF = 16;
    localparam int CFG_DATA_BITS   = 24;
    localparam int CFG_IDX_BITS    = 2;
    localparam int GAIN_BITS       = 16;
    localparam logic [GAIN_BITS-1:0] UNITY = 16'd32768;

    typedef enum logic [CFG_IDX_BITS-1:0] {
        REG_ATTACK  = 2'd0,
        REG_DECAY   = 2'd1,
        REG_SUSTAIN = 2'd2,
        REG_RELEASE = 2'd3
    } cfg_reg_t;

    typedef enum logic [1:0] {
        PH_ATTACK  = 2'd0,
        PH_DECAY   = 2'd1,
        PH_CONST   = 2'd2
    } phase_t;
endpackage

// ----- rtl/aeg_stream_if.sv -----
// Valid/ready stream interface.
`timescale 1ns / 1ps
interface aeg_stream_if #(
    parameter type payload_t = logic
);
    logic     valid;
    logic     ready;
    payload_t data;
    modport source (output valid, output data, input ready);
    modport sink (input valid, input data, output ready);
endinterface

// ----- rtl/aeg_divider.sv -----
// Pipelined restoring divider, one quotient bit per stage, with side-band tag.
`timescale 1ns / 1ps
module aeg_divider #(
    parameter int NUM_BITS = 40,
    parameter int DEN_BITS = 24,
    parameter int TAG_BITS = 8
) (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                en,
    input  logic                in_valid,
    input  logic [NUM_BITS-1:0] num,
    input  logic [DEN_BITS-1:0] den,
    input  logic [TAG_BITS-1:0] tag_in,
    output logic                out_valid,
    output logic [NUM_BITS-1:0] quo,
    output logic [TAG_BITS-1:0] tag_out
);
    localparam int REM_BITS = DEN_BITS + 1;

    logic [NUM_BITS:0]   valid_reg;
    logic [NUM_BITS-1:0] num_reg [NUM_BITS+1];
    logic [REM_BITS-1:0] rem_reg [NUM_BITS+1];
    logic [DEN_BITS-1:0] den_reg [NUM_BITS+1];
    logic [TAG_BITS-1:0] tag_reg [NUM_BITS+1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else if (en)
        begin
            valid_reg <= {valid_reg[NUM_BITS-1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0] <= num;
            rem_reg[0] <= '0;
            den_reg[0] <= den;
            tag_reg[0] <= tag_in;
        end
    end

    for (genvar s = 0; s < NUM_BITS; s++)
    begin : g_stage
        logic [REM_BITS:0] trial;
        logic [REM_BITS:0] diff;
        assign trial = {rem_reg[s], num_reg[s][NUM_BITS-1]};
        assign diff  = trial - {2'b00, den_reg[s]};
        always_ff @(posedge clk)
        begin
            if (en)
            begin
                if (!diff[REM_BITS])
                begin
                    rem_reg[s+1] <= diff[REM_BITS-1:0];
                    num_reg[s+1] <= {num_reg[s][NUM_BITS-2:0], 1'b1};
                end
                else
                begin
                    rem_reg[s+1] <= trial[REM_BITS-1:0];
                    num_reg[s+1] <= {num_reg[s][NUM_BITS-2:0], 1'b0};
                end
                den_reg[s+1] <= den_reg[s];
                tag_reg[s+1] <= tag_reg[s];
            end
        end
    end

    assign out_valid = valid_reg[NUM_BITS];
    assign quo       = num_reg[NUM_BITS];
    assign tag_out   = tag_reg[NUM_BITS];
endmodule

// ----- rtl/adsr_envelope_gain_unit.sv -----
// Top level: linear ADSR envelope gain applied to a sample stream.
// One transaction in and one out per cycle unless the pipeline stalls. With DB the larger of
// TIME_BITS and 24, an item passes DB+22 registers: a setup stage, a numerator product stage,
// a pipelined divider, a gain stage, a multiply stage and an output register. The whole
// pipeline stalls when the output register is full and not taken. Write configuration only
// while the pipeline is empty.
`timescale 1ns / 1ps
module adsr_envelope_gain_unit #(
    parameter int TIME_BITS   = aeg_pkg::TIME_BITS_DEF,
    parameter int SAMPLE_BITS = aeg_pkg::SAMPLE_BITS_DEF
) (
    input  logic                              clk,
    input  logic                              rst_n,
    input  logic                              cfg_we,
    input  logic [aeg_pkg::CFG_IDX_BITS-1:0]  cfg_index,
    input  logic [aeg_pkg::CFG_DATA_BITS-1:0] cfg_data,
    input  logic                              in_valid,
    output logic                              in_ready,
    input  logic [TIME_BITS-1:0]              since_press,
    input  logic [TIME_BITS-1:0]              since_release,
    input  logic                              key_held,
    input  logic signed [SAMPLE_BITS-1:0]     sample_in,
    output logic                              out_valid,
    input  logic                              out_ready,
    output logic signed [SAMPLE_BITS-1:0]     sample_out,
    output logic [aeg_pkg::GAIN_BITS-1:0]     gain
);
    import aeg_pkg::*;
    `include "adsr_envelope_gain_unit_macros.svh"

    localparam int CB  = CFG_DATA_BITS;
    localparam int DB  = (TIME_BITS > CB) ? TIME_BITS : CB;
    localparam int NB  = DB + 16;
    localparam int TAG = 2 + GAIN_BITS + SAMPLE_BITS;
    localparam int PB  = SAMPLE_BITS + GAIN_BITS + 1;

    logic [CB-1:0]        attack_reg, decay_reg, release_reg;
    logic [GAIN_BITS-1:0] sustain_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attack_reg  <= '0;
            decay_reg   <= '0;
            release_reg <= '0;
            sustain_reg <= UNITY;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_ATTACK:  attack_reg  <= cfg_data;
                REG_DECAY:   decay_reg   <= cfg_data;
                REG_SUSTAIN: sustain_reg <= cfg_data[GAIN_BITS-1:0];
                REG_RELEASE: release_reg <= cfg_data;
                default:     ;
            endcase
        end
    end

    logic en;
    logic out_valid_reg;
    assign en       = !out_valid_reg || out_ready;
    assign in_ready = en;

    // Stage 1: phase select and divider operands.
    logic [GAIN_BITS-1:0] s_sat;
    logic [DB:0] t_x, r_x, a_x, d_x, rl_x, ad_x, ta_x;
    logic [DB-1:0] dnum, dden;
    logic [GAIN_BITS-1:0] dmul, cval;
    phase_t ph;
    assign s_sat = (sustain_reg > UNITY) ? UNITY : sustain_reg;
    assign t_x  = (DB+1)'(since_press);
    assign r_x  = (DB+1)'(since_release);
    assign a_x  = (DB+1)'(attack_reg);
    assign d_x  = (DB+1)'(decay_reg);
    assign rl_x = (DB+1)'(release_reg);
    assign ad_x = a_x + d_x;
    assign ta_x = t_x - a_x;

    always_comb
    begin
        dnum = '0;
        dden = '1;
        dmul = '0;
        cval = '0;
        ph   = PH_CONST;
        if (!key_held)
        begin
            if (r_x < rl_x)
            begin
                ph   = PH_ATTACK;
                dnum = DB'(rl_x - r_x);
                dden = DB'(rl_x);
                dmul = s_sat;
            end
        end
        else if (t_x < a_x)
        begin
            ph   = PH_ATTACK;
            dnum = DB'(t_x);
            dden = DB'(a_x);
            dmul = UNITY;
        end
        else if (t_x < ad_x)
        begin
            ph   = PH_DECAY;
            dnum = DB'(ta_x);
            dden = DB'(d_x);
            dmul = UNITY - s_sat;
        end
        else
        begin
            cval = s_sat;
        end
    end

    logic                 v1_reg;
    logic [DB-1:0]        n1_reg, d1_reg;
    logic [GAIN_BITS-1:0] m1_reg, c1_reg;
    phase_t               ph1_reg;
    logic signed [SAMPLE_BITS-1:0] smp1_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
        end
        else if (en)
        begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n1_reg   <= dnum;
            d1_reg   <= dden;
            m1_reg   <= dmul;
            c1_reg   <= cval;
            ph1_reg  <= ph;
            smp1_reg <= sample_in;
        end
    end

    // Stage 2: product that feeds the divider.
    logic                 v2_reg;
    logic [NB-1:0]        n2_reg;
    logic [DB-1:0]        d2_reg;
    logic [TAG-1:0]       tag2_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v2_reg <= 1'b0;
        end
        else if (en)
        begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            n2_reg   <= NB'(n1_reg) * NB'(m1_reg);
            d2_reg   <= d1_reg;
            tag2_reg <= {ph1_reg, c1_reg, smp1_reg};
        end
    end

    logic           dv;
    logic [NB-1:0]  dq;
    logic [TAG-1:0] dtag;

    aeg_divider #(
        .NUM_BITS (NB),
        .DEN_BITS (DB),
        .TAG_BITS (TAG)
    ) u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (en),
        .in_valid  (v2_reg),
        .num       (n2_reg),
        .den       (d2_reg),
        .tag_in    (tag2_reg),
        .out_valid (dv),
        .quo       (dq),
        .tag_out   (dtag)
    );

    // Stage 3: gain.
    phase_t               dph;
    logic [GAIN_BITS-1:0] dc, g_next;
    logic signed [SAMPLE_BITS-1:0] dsmp;
    assign dph  = phase_t'(dtag[TAG-1 -: 2]);
    assign dc   = dtag[SAMPLE_BITS +: GAIN_BITS];
    assign dsmp = dtag[SAMPLE_BITS-1:0];

    always_comb
    begin
        case (dph)
            PH_ATTACK: g_next = dq[GAIN_BITS-1:0];
            PH_DECAY:  g_next = UNITY - dq[GAIN_BITS-1:0];
            default:   g_next = dc;
        endcase
    end

    logic                 v3_reg;
    logic [GAIN_BITS-1:0] g3_reg;
    logic signed [SAMPLE_BITS-1:0] smp3_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v3_reg <= 1'b0;
        end
        else if (en)
        begin
            v3_reg <= dv;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            g3_reg   <= g_next;
            smp3_reg <= dsmp;
        end
    end

    // Stage 4: multiply, arithmetic shift floors the Q1.15 product.
    logic                 v4_reg;
    logic signed [PB-1:0] p4_reg;
    logic [GAIN_BITS-1:0] g4_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v4_reg <= 1'b0;
        end
        else if (en)
        begin
            v4_reg <= v3_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            p4_reg <= PB'(smp3_reg) * $signed({1'b0, g3_reg});
            g4_reg <= g3_reg;
        end
    end

    logic signed [PB-1:0] p_sh;
    assign p_sh = p4_reg >>> 15;

    // Output register.
    logic signed [SAMPLE_BITS-1:0] so_reg;
    logic [GAIN_BITS-1:0]          go_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            out_valid_reg <= v4_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            so_reg <= p_sh[SAMPLE_BITS-1:0];
            go_reg <= g4_reg;
        end
    end

    assign out_valid  = out_valid_reg;
    assign sample_out = so_reg;
    assign gain       = go_reg;

    `AEG_ASSERT_IMP(a_gain_max, clk, rst_n, out_valid, gain <= UNITY, "gain above unity")
    `AEG_ASSERT_NEXT(a_stall_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(gain), "stalled result changed")
    `AEG_ASSERT_IMP(a_ready, clk, rst_n, !out_valid, in_ready, "not ready with empty output")
endmodule

// ----- verif/tb_adsr_envelope_gain_unit.sv -----
// Self-checking testbench for the ADSR envelope gain unit: predicted gain and scaled sample.
`timescale 1ns / 1ps

module tb_adsr_envelope_gain_unit;
    import aeg_pkg::*;

    localparam int TB = 24;
    localparam int SB = 16;
    localparam int WATCHDOG_LIMIT = 4000;
    localparam int DRAIN_CYCLES = 120;

    typedef struct packed {
        logic [TB-1:0]        since_press;
        logic [TB-1:0]        since_release;
        logic                 key_held;
        logic signed [SB-1:0] sample_in;
    } env_in_t;

    typedef struct packed {
        logic signed [SB-1:0]  sample_out;
        logic [GAIN_BITS-1:0]  gain;
    } env_out_t;

    class envelope_scoreboard;
        logic [23:0] attack_len;
        logic [23:0] decay_len;
        logic [15:0] sustain_reg;
        logic [23:0] release_len;
        env_out_t    pending_q[$];
        int          mismatches;
        int          checked;

        function new();
            attack_len  = 0;
            decay_len   = 0;
            sustain_reg = UNITY;
            release_len = 0;
            mismatches  = 0;
            checked     = 0;
        endfunction

        function void set_reg(cfg_reg_t idx, logic [23:0] val);
            case (idx)
                REG_ATTACK:  attack_len  = val;
                REG_DECAY:   decay_len   = val;
                REG_SUSTAIN: sustain_reg = val[15:0];
                REG_RELEASE: release_len = val;
                default:     ;
            endcase
        endfunction

        function void note_input(env_in_t it);
            longint unsigned t, r, a, d, rl, s, g;
            longint p;
            env_out_t e;
            t  = it.since_press;
            r  = it.since_release;
            a  = attack_len;
            d  = decay_len;
            rl = release_len;
            s  = (sustain_reg > UNITY) ? UNITY : sustain_reg;
            if (t < a)
                g = (t * 32768) / a;
            else if (t < a + d)
                g = 32768 - ((32768 - s) * (t - a)) / d;
            else
                g = s;
            if (!it.key_held)
                g = (r >= rl) ? 0 : (s * (rl - r)) / rl;
            p = longint'(it.sample_in) * longint'(g);
            e.sample_out = SB'(p >>> 15);
            e.gain = g[15:0];
            pending_q.push_back(e);
        endfunction

        function void check_result(env_out_t got);
            env_out_t e;
            if (pending_q.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: unexpected result sample_out=%0d gain=%0d",
                             got.sample_out, got.gain);
                return;
            end
            e = pending_q.pop_front();
            checked++;
            if (got.sample_out !== e.sample_out || got.gain !== e.gain)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("ERROR: sample_out exp %0d got %0d, gain exp %0d got %0d",
                             e.sample_out, got.sample_out, e.gain, got.gain);
            end
        endfunction
    endclass

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [CFG_IDX_BITS-1:0] cfg_index;
    logic [CFG_DATA_BITS-1:0] cfg_data;

    aeg_stream_if #(.payload_t(env_in_t))  in_if ();
    aeg_stream_if #(.payload_t(env_out_t)) out_if ();

    envelope_scoreboard sb;
    int snd_idle;
    int rcv_idle;
    int hold_cycles;
    int quiet_cycles;
    int sent;

    adsr_envelope_gain_unit uut (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_we        (cfg_we),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .in_valid      (in_if.valid),
        .in_ready      (in_if.ready),
        .since_press   (in_if.data.since_press),
        .since_release (in_if.data.since_release),
        .key_held      (in_if.data.key_held),
        .sample_in     (in_if.data.sample_in),
        .out_valid     (out_if.valid),
        .out_ready     (out_if.ready),
        .sample_out    (out_if.data.sample_out),
        .gain          (out_if.data.gain)
    );

    always
    begin
        clk = 1'b0;
        #10;
        clk = 1'b1;
        #10;
    end

    // sink side: random stalls plus long hold-off on request
    always @(negedge clk)
    begin
        if (hold_cycles > 0)
        begin
            out_if.ready <= 1'b0;
            hold_cycles <= hold_cycles - 1;
        end
        else
            out_if.ready <= ($urandom_range(99) >= rcv_idle);
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_if.valid && in_if.ready)
                sb.note_input(in_if.data);
            if (out_if.valid && out_if.ready)
                sb.check_result(out_if.data);
            if ((in_if.valid && in_if.ready) || (out_if.valid && out_if.ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no transaction for %0d cycles", WATCHDOG_LIMIT);
                $display("adsr_envelope_gain_unit test failed");
                $finish;
            end
        end
    end

    task automatic send_item(env_in_t it);
        while ($urandom_range(99) < snd_idle)
        begin
            in_if.valid <= 1'b0;
            @(negedge clk);
        end
        in_if.valid <= 1'b1;
        in_if.data  <= it;
        do
            @(posedge clk);
        while (!in_if.ready);
        @(negedge clk);
        sent++;
    endtask

    task automatic wait_idle();
        in_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (60) @(negedge clk);
    endtask

    task automatic write_reg(cfg_reg_t idx, logic [23:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(negedge clk);
        cfg_we    <= 1'b0;
        sb.set_reg(idx, val);
    endtask

    task automatic configure(logic [23:0] a, logic [23:0] d, logic [15:0] s, logic [23:0] r);
        wait_idle();
        write_reg(REG_ATTACK, a);
        write_reg(REG_DECAY, d);
        write_reg(REG_SUSTAIN, s);
        write_reg(REG_RELEASE, r);
    endtask

    function automatic env_in_t make_item(logic [23:0] t, logic [23:0] r, logic held,
                                          logic [15:0] smp);
        env_in_t it;
        it.since_press   = t;
        it.since_release = r;
        it.key_held      = held;
        it.sample_in     = smp;
        return it;
    endfunction

    function automatic logic [23:0] pick_tick(longint unsigned span);
        longint unsigned v;
        if ($urandom_range(9) == 0)
            return 24'($urandom);
        if ($urandom_range(5) == 0)
            v = span - $urandom_range(3);
        else
            v = $urandom_range((span > 32'h7fff_ffff) ? 32'h7fff_ffff : int'(span));
        return (v > 24'hffffff) ? 24'hffffff : v[23:0];
    endfunction

    function automatic env_in_t random_item();
        logic [15:0] smp;
        case ($urandom_range(7))
            0: smp = 16'h8000;
            1: smp = 16'h7fff;
            default: smp = 16'($urandom);
        endcase
        return make_item(pick_tick(longint'(sb.attack_len) + sb.decay_len + 40),
                         pick_tick(longint'(sb.release_len) + 20),
                         1'($urandom_range(1)), smp);
    endfunction

    task automatic random_phase(int n);
        repeat (n) send_item(random_item());
    endtask

    initial
    begin
        sb = new();
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_index = REG_ATTACK;
        cfg_data = '0;
        in_if.valid = 1'b0;
        in_if.data = '0;
        out_if.ready = 1'b0;
        hold_cycles = 0;
        quiet_cycles = 0;
        sent = 0;
        snd_idle = 29;
        rcv_idle = 71;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // reset defaults: attack and decay skipped, full sustain, release at once
        send_item(make_item(24'd0, 24'd0, 1'b1, 16'h7fff));
        send_item(make_item(24'hffffff, 24'd0, 1'b0, 16'h8000));
        send_item(make_item(24'd5, 24'hffffff, 1'b1, 16'hffff));

        configure(24'd100, 24'd200, 16'd16384, 24'd300);
        send_item(make_item(24'd0, 24'd0, 1'b1, 16'h8000));
        send_item(make_item(24'd50, 24'd0, 1'b1, 16'h7fff));
        send_item(make_item(24'd99, 24'd0, 1'b1, 16'hffff));
        send_item(make_item(24'd100, 24'd0, 1'b1, 16'h8000));
        send_item(make_item(24'd150, 24'd0, 1'b1, 16'h0001));
        send_item(make_item(24'd299, 24'd0, 1'b1, 16'h7fff));
        send_item(make_item(24'd300, 24'd0, 1'b1, 16'h8000));
        send_item(make_item(24'hffffff, 24'd0, 1'b1, 16'h0000));
        send_item(make_item(24'd20, 24'd0, 1'b0, 16'h8000));
        send_item(make_item(24'd20, 24'd150, 1'b0, 16'h7fff));
        send_item(make_item(24'd20, 24'd299, 1'b0, 16'hffff));
        send_item(make_item(24'd20, 24'd300, 1'b0, 16'h8000));
        send_item(make_item(24'd20, 24'hffffff, 1'b0, 16'h7fff));
        random_phase(180);

        configure(24'hffffff, 24'hffffff, 16'hffff, 24'hffffff);
        send_item(make_item(24'hfffffe, 24'd0, 1'b1, 16'h7fff));
        send_item(make_item(24'hffffff, 24'd1, 1'b0, 16'h8000));
        random_phase(180);

        snd_idle = 71;
        rcv_idle = 29;
        configure(24'd1, 24'd1, 16'd0, 24'd1);
        random_phase(180);
        configure(24'd0, 24'd37, 16'd32768, 24'd9);
        random_phase(180);

        snd_idle = 0;
        rcv_idle = 0;
        configure(24'($urandom_range(600)), 24'($urandom_range(600)),
                  16'($urandom_range(32768)), 24'($urandom_range(600)));
        hold_cycles = 300;
        random_phase(200);
        configure(24'd0, 24'd0, 16'd32769, 24'd5000);
        random_phase(200);

        in_if.valid <= 1'b0;
        while (sb.pending_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
        $display("Ran %0d transactions over seven register settings; %0d results checked.",
                 sent, sb.checked);
        $display("Covered attack, decay, sustain, release, zero lengths and sustain clamp.");
        if (sb.mismatches == 0 && sb.pending_q.size() == 0)
            $display("adsr_envelope_gain_unit test passed");
        else
            $display("adsr_envelope_gain_unit test failed");
        $finish;
    end
endmodule

// ----- adsr_envelope_gain_unit.f -----
+incdir+rtl
rtl/aeg_pkg.sv
rtl/aeg_stream_if.sv
rtl/aeg_divider.sv
rtl/adsr_envelope_gain_unit.sv
verif/tb_adsr_envelope_gain_unit.sv
